### rtl/rse_pkg.sv
package rse_pkg;

	// unit vectors are Q.28, magnitude at most 2^28
	localparam int UNIT_SHIFT = 28;
	// normalizer scales the largest component into [2^29, 2^30)
	localparam int SCALE_W = 30;
	localparam int ROOT_W = 31;
	localparam int SQRT_STEPS = ROOT_W;
	localparam int DIV_STEPS = UNIT_SHIFT + 1;
	// cycles from normalizer input to output
	localparam int NORM_LAT = 5 + SQRT_STEPS + DIV_STEPS;

	typedef logic signed [63:0] vec64_t;
	typedef logic [UNIT_SHIFT:0] umag_t;

	typedef enum logic [1:0] {
		REG_CAMERA_X,
		REG_CAMERA_Y,
		REG_CAMERA_Z,
		REG_BASE_HALF_WIDTH
	} reg_idx_t;

endpackage

### rtl/rse_norm.sv
module rse_norm import rse_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  vec64_t     in_vec [3],
	output logic       out_valid,
	output umag_t      out_mag [3],
	output logic [2:0] out_neg
);

	typedef struct packed {
		logic [2:0][SCALE_W-1:0] sc;
		logic [2:0]              neg;
		logic                    zero;
	} npay_t;

	// front: magnitudes, max, msb search, scaling, squares, sum
	logic [63:0]         mag_s1 [3];
	logic [2:0]          neg_s1;
	logic [63:0]         max_s1;
	logic                v_s1;
	logic [63:0]         mag_s2 [3];
	logic [2:0]          neg_s2;
	logic [5:0]          pos_s2;
	logic                zero_s2;
	logic                v_s2;
	npay_t               pay_s3;
	logic                v_s3;
	npay_t               pay_s4;
	logic [59:0]         sqr_s4 [3];
	logic                v_s4;

	logic [63:0]         mag_c [3];
	logic [63:0]         max_c;
	logic [5:0]          pos_c;
	logic [63:0]         shf_c [3];

	// isqrt pipeline, one root bit per stage; index 0 is the sum register
	logic [61:0]         rem_sq [0:SQRT_STEPS];
	logic [ROOT_W-1:0]   root_sq [0:SQRT_STEPS];
	npay_t               pay_sq [0:SQRT_STEPS];
	logic                v_sq [0:SQRT_STEPS];

	// divider pipeline, one quotient bit per stage
	logic [2:0][31:0]         rem_dv [0:DIV_STEPS];
	logic [2:0][UNIT_SHIFT:0] quo_dv [0:DIV_STEPS];
	logic [ROOT_W-1:0]        den_dv [0:DIV_STEPS];
	logic [2:0]               neg_dv [0:DIV_STEPS];
	logic                     zero_dv [0:DIV_STEPS];
	logic                     v_dv [0:DIV_STEPS];

	always_comb begin
		max_c = '0;
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = in_vec[i][63] ? $unsigned(-in_vec[i]) : $unsigned(in_vec[i]);
			if (mag_c[i] > max_c) begin
				max_c = mag_c[i];
			end
		end
	end

	always_comb begin
		pos_c = '0;
		for (int b = 0; b < 64; b++) begin
			if (max_s1[b]) begin
				pos_c = 6'(b);
			end
		end
	end

	// bring the largest component into [2^29, 2^30); right shift truncates toward zero
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (pos_s2 >= 6'(SCALE_W)) begin
				shf_c[i] = mag_s2[i] >> (pos_s2 - 6'(SCALE_W - 1));
			end else begin
				shf_c[i] = mag_s2[i] << (6'(SCALE_W - 1) - pos_s2);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_sq[0] <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_sq[0] <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			mag_s1[i] <= mag_c[i];
			neg_s1[i] <= in_vec[i][63];
			mag_s2[i] <= mag_s1[i];
			pay_s3.sc[i] <= shf_c[i][SCALE_W-1:0];
			sqr_s4[i] <= 60'(pay_s3.sc[i]) * 60'(pay_s3.sc[i]);
		end
		max_s1 <= max_c;
		neg_s2 <= neg_s1;
		pos_s2 <= pos_c;
		zero_s2 <= (max_s1 == '0);
		pay_s3.neg <= neg_s2;
		pay_s3.zero <= zero_s2;
		pay_s4 <= pay_s3;
		rem_sq[0] <= 62'(sqr_s4[0]) + 62'(sqr_s4[1]) + 62'(sqr_s4[2]);
		root_sq[0] <= '0;
		pay_sq[0] <= pay_s4;
	end

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		localparam int B = SQRT_STEPS - 1 - k;
		logic [63:0] trial;
		logic        take;

		always_comb begin
			trial = ({33'd0, root_sq[k]} << (B + 1)) | (64'd1 << (2 * B));
			take = {2'b00, rem_sq[k]} >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sq[k+1] <= 1'b0;
			end else begin
				v_sq[k+1] <= v_sq[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_sq[k+1] <= take ? 62'({2'b00, rem_sq[k]} - trial) : rem_sq[k];
			root_sq[k+1] <= take ? (root_sq[k] | (ROOT_W'(1) << B)) : root_sq[k];
			pay_sq[k+1] <= pay_sq[k];
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rem_dv[0][i] = {2'b00, pay_sq[SQRT_STEPS].sc[i]};
		end
		quo_dv[0] = '0;
		den_dv[0] = root_sq[SQRT_STEPS];
		neg_dv[0] = pay_sq[SQRT_STEPS].neg;
		zero_dv[0] = pay_sq[SQRT_STEPS].zero;
		v_dv[0] = v_sq[SQRT_STEPS];
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [2:0][31:0]         nrem;
		logic [2:0][UNIT_SHIFT:0] nquo;

		// first step compares the scaled value itself (quotient bit 28)
		always_comb begin
			logic [31:0] r2;
			logic        take;
			for (int l = 0; l < 3; l++) begin
				r2 = (k == 0) ? rem_dv[k][l] : {rem_dv[k][l][30:0], 1'b0};
				take = r2 >= {1'b0, den_dv[k]};
				nrem[l] = take ? (r2 - {1'b0, den_dv[k]}) : r2;
				nquo[l] = {quo_dv[k][l][UNIT_SHIFT-1:0], take};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_dv[k+1] <= 1'b0;
			end else begin
				v_dv[k+1] <= v_dv[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_dv[k+1] <= nrem;
			quo_dv[k+1] <= nquo;
			den_dv[k+1] <= den_dv[k];
			neg_dv[k+1] <= neg_dv[k];
			zero_dv[k+1] <= zero_dv[k];
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			out_mag[i] = zero_dv[DIV_STEPS] ? '0 : quo_dv[DIV_STEPS][i];
		end
		out_neg = neg_dv[DIV_STEPS];
		out_valid = v_dv[DIV_STEPS];
	end

endmodule

### rtl/ribbon_segment_extrude.sv
// A segment leaves as two vertices, the second in the cycle after the first.
// busy is raised by each accepted segment and blocks start, as both vertices
// share the single result port; earlier segments may still be in the pipeline.
// Each of the two normalizers (isqrt then divide, one bit per stage) is 65 deep.
// Results cannot be held off by the receiver; the pipeline never stalls.
// Reset (arst_n low) clears all valid bits and loads the register defaults.
module ribbon_segment_extrude import rse_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [31:0]        wr_data,
	input  logic signed [31:0] prev_x,
	input  logic signed [31:0] prev_y,
	input  logic signed [31:0] prev_z,
	input  logic signed [31:0] cur_x,
	input  logic signed [31:0] cur_y,
	input  logic signed [31:0] cur_z,
	input  logic [30:0]        point_age,
	input  logic [30:0]        turn_rate,
	input  logic [30:0]        speed,
	output logic               vert_strobe,
	output logic signed [31:0] vert_x,
	output logic signed [31:0] vert_y,
	output logic signed [31:0] vert_z,
	output logic [30:0]        vert_age,
	output logic [30:0]        vert_turn_rate,
	output logic [30:0]        vert_speed,
	output logic               side,
	output logic               last
);

	typedef struct packed {
		logic [2:0][31:0] cur;
		logic [30:0]      age;
		logic [30:0]      turn;
		logic [30:0]      speed;
	} sb_t;

	localparam logic [30:0] BASE_RST = 31'd2621;
	localparam logic [30:0] W_MAX = 31'h7fffffff;
	localparam logic [63:0] BIG_LIM = 64'd1 << 30;
	localparam longint PERP_EPS = 64'd175921860;
	// floor(sqrt(x)) > eps  <=>  x >= (eps + 1)^2
	localparam logic [63:0] PERP_EPS_SQ = 64'(PERP_EPS + 1) * 64'(PERP_EPS + 1);
	localparam logic signed [33:0] SAT_HI = 34'sd2147483647;
	localparam logic signed [33:0] SAT_LO = -34'sd2147483648;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > SAT_HI) begin
			r = 32'sh7fffffff;
		end else if (v < SAT_LO) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	logic signed [31:0] cam_q [3];
	logic [30:0]        base_q;
	logic               busy_q;
	logic               pend_q;
	logic               accept;

	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic               v_s8, v_s9, v_s10, v_s11;
	logic signed [32:0] d_s1 [3];
	sb_t                sb_s1, sb_s2, sb_s3, sb_s4, sb_s5, sb_s6, sb_s7;
	sb_t                sb_s8, sb_s9, sb_s10, sb_s11;
	sb_t                dl1_s [0:NORM_LAT-1];
	sb_t                dl2_s [0:NORM_LAT-1];

	logic signed [29:0] dir_s2 [3], dir_s3 [3], dir_s4 [3], dir_s5 [3];
	logic signed [29:0] dir_s6 [3], dir_s7 [3];
	logic signed [32:0] t_s2 [3];
	logic signed [62:0] p_s3 [6];
	logic signed [63:0] q_s4 [3], q_s5 [3], q_s6 [3], q_s7 [3];
	logic [63:0]        qmag_s5 [3];
	logic [61:0]        sqr_s6 [3];
	logic               big_s6;
	logic               long_s7;

	umag_t              pdm_s8 [3], pdm_s9 [3];
	logic [2:0]         pdn_s8, pdn_s9, pdn_s10;
	logic [33:0]        f_s8;
	logic [30:0]        w_s9;
	logic [31:0]        offm_s10 [3];
	logic signed [31:0] minus_s11 [3], plus_s11 [3];

	vec64_t             n1_in [3], n2_in [3];
	logic               n1_v, n2_v;
	umag_t              n1_mag [3], n2_mag [3];
	logic [2:0]         n1_neg, n2_neg;

	logic [63:0]        qsum;
	logic [64:0]        wprod;
	logic [59:0]        oprod [3];
	logic signed [33:0] off_c [3];
	logic signed [33:0] cur_c [3];

	assign accept = start && !busy_q;
	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_q[0] <= '0;
			cam_q[1] <= '0;
			cam_q[2] <= '0;
			base_q <= BASE_RST;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_CAMERA_X: cam_q[0] <= $signed(wr_data);
				REG_CAMERA_Y: cam_q[1] <= $signed(wr_data);
				REG_CAMERA_Z: cam_q[2] <= $signed(wr_data);
				REG_BASE_HALF_WIDTH: base_q <= wr_data[30:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else begin
			busy_q <= accept;
			v_s1 <= accept;
			v_s2 <= n1_v;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= n2_v;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	// segment direction
	always_ff @(posedge clk) begin
		d_s1[0] <= 33'(cur_x) - 33'(prev_x);
		d_s1[1] <= 33'(cur_y) - 33'(prev_y);
		d_s1[2] <= 33'(cur_z) - 33'(prev_z);
		sb_s1.cur <= {cur_z, cur_y, cur_x};
		sb_s1.age <= point_age;
		sb_s1.turn <= turn_rate;
		sb_s1.speed <= speed;
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			n1_in[i] = 64'(d_s1[i]);
		end
	end

	rse_norm u_norm_dir (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s1),
		.in_vec   (n1_in),
		.out_valid(n1_v),
		.out_mag  (n1_mag),
		.out_neg  (n1_neg)
	);

	always_ff @(posedge clk) begin
		dl1_s[0] <= sb_s1;
		dl2_s[0] <= sb_s7;
		for (int k = 1; k < NORM_LAT; k++) begin
			dl1_s[k] <= dl1_s[k-1];
			dl2_s[k] <= dl2_s[k-1];
		end
	end

	// perpendicular Q = dir x (camera - cur), then its length test
	always_comb begin
		qsum = 64'(sqr_s6[0]) + 64'(sqr_s6[1]) + 64'(sqr_s6[2]);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dir_s2[i] <= n1_neg[i] ? -$signed({1'b0, n1_mag[i]}) : $signed({1'b0, n1_mag[i]});
			t_s2[i] <= 33'(cam_q[i]) - 33'($signed(dl1_s[NORM_LAT-1].cur[i]));
			dir_s3[i] <= dir_s2[i];
			dir_s4[i] <= dir_s3[i];
			dir_s5[i] <= dir_s4[i];
			dir_s6[i] <= dir_s5[i];
			dir_s7[i] <= dir_s6[i];
			q_s5[i] <= q_s4[i];
			qmag_s5[i] <= q_s4[i][63] ? $unsigned(-q_s4[i]) : $unsigned(q_s4[i]);
			q_s6[i] <= q_s5[i];
			sqr_s6[i] <= 62'(qmag_s5[i][30:0]) * 62'(qmag_s5[i][30:0]);
			q_s7[i] <= q_s6[i];
		end
		sb_s2 <= dl1_s[NORM_LAT-1];
		p_s3[0] <= dir_s2[1] * t_s2[2];
		p_s3[1] <= dir_s2[2] * t_s2[1];
		p_s3[2] <= dir_s2[2] * t_s2[0];
		p_s3[3] <= dir_s2[0] * t_s2[2];
		p_s3[4] <= dir_s2[0] * t_s2[1];
		p_s3[5] <= dir_s2[1] * t_s2[0];
		sb_s3 <= sb_s2;
		q_s4[0] <= 64'(p_s3[0]) - 64'(p_s3[1]);
		q_s4[1] <= 64'(p_s3[2]) - 64'(p_s3[3]);
		q_s4[2] <= 64'(p_s3[4]) - 64'(p_s3[5]);
		sb_s4 <= sb_s3;
		sb_s5 <= sb_s4;
		// squares only matter when no component exceeds 2^30
		big_s6 <= (qmag_s5[0] > BIG_LIM) || (qmag_s5[1] > BIG_LIM) || (qmag_s5[2] > BIG_LIM);
		sb_s6 <= sb_s5;
		long_s7 <= big_s6 || (qsum >= PERP_EPS_SQ);
		sb_s7 <= sb_s6;
	end

	// fallback is dir x up = (-dz, 0, dx)
	always_comb begin
		n2_in[0] = long_s7 ? q_s7[0] : -64'(dir_s7[2]);
		n2_in[1] = long_s7 ? q_s7[1] : '0;
		n2_in[2] = long_s7 ? q_s7[2] : 64'(dir_s7[0]);
	end

	rse_norm u_norm_perp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s7),
		.in_vec   (n2_in),
		.out_valid(n2_v),
		.out_mag  (n2_mag),
		.out_neg  (n2_neg)
	);

	// half-width, offsets, vertices
	always_comb begin
		wprod = 65'(base_q) * 65'(f_s8);
		for (int i = 0; i < 3; i++) begin
			oprod[i] = 60'(pdm_s9[i]) * 60'(w_s9);
			off_c[i] = pdn_s10[i] ? -$signed({2'b00, offm_s10[i]}) : $signed({2'b00, offm_s10[i]});
			cur_c[i] = 34'($signed(sb_s10.cur[i]));
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pdm_s8[i] <= n2_mag[i];
			pdm_s9[i] <= pdm_s8[i];
			offm_s10[i] <= oprod[i][59:28];
		end
		pdn_s8 <= n2_neg;
		f_s8 <= 34'd65536 + 34'(dl2_s[NORM_LAT-1].age) * 34'd3;
		sb_s8 <= dl2_s[NORM_LAT-1];
		pdn_s9 <= pdn_s8;
		w_s9 <= (wprod[64:16] > 49'(W_MAX)) ? W_MAX : wprod[46:16];
		sb_s9 <= sb_s8;
		pdn_s10 <= pdn_s9;
		sb_s10 <= sb_s9;
		// held for the second vertex of the pair
		if (v_s10) begin
			for (int i = 0; i < 3; i++) begin
				minus_s11[i] <= sat32(cur_c[i] - off_c[i]);
				plus_s11[i] <= sat32(cur_c[i] + off_c[i]);
			end
			sb_s11 <= sb_s10;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vert_strobe <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			vert_strobe <= v_s11 || pend_q;
			pend_q <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		vert_x <= pend_q ? plus_s11[0] : minus_s11[0];
		vert_y <= pend_q ? plus_s11[1] : minus_s11[1];
		vert_z <= pend_q ? plus_s11[2] : minus_s11[2];
		vert_age <= sb_s11.age;
		vert_turn_rate <= sb_s11.turn;
		vert_speed <= sb_s11.speed;
		side <= pend_q;
		last <= pend_q;
	end

`ifndef SYNTHESIS
	a_pair_second: assert property (@(posedge clk) disable iff (!arst_n)
		vert_strobe && !side |=> vert_strobe && side)
		else $error("first vertex not followed by second");
	a_pair_first: assert property (@(posedge clk) disable iff (!arst_n)
		vert_strobe && side |-> $past(vert_strobe) && !$past(side))
		else $error("second vertex without first");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		v_s11 |-> !pend_q)
		else $error("new item reached output while pair pending");
`endif

endmodule
